[rtl/dtrd_pkg.sv]
`default_nettype none
package dtrd_pkg;

	// Field widths fixed by the record format and the result format.
	localparam int BYTE_W = 8;
	localparam int WORD_W = 32;
	localparam int PAIR_W = 64;
	localparam int OUT_W = 48;
	localparam int OUT_FRAC_BITS = 16;
	localparam int HEADER_BYTES = 16;
	localparam int CFG_IDX_W = 3;

	// Default fixed-point formats.
	localparam int SUBVOXEL_BITS_DEF = 5;
	localparam int COEFF_FRAC_BITS_DEF = 16;

	// Result kinds.
	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_BAD_LEN = 2'd2;
	localparam logic [1:0] KIND_OVERRUN = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_A = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_B = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BUF_LEN = 3'd6;

	// Reset values of the coefficient pairs: identity, no translation.
	localparam logic [PAIR_W-1:0] ROW0_A_RST = 64'h0000_0000_0001_0000;
	localparam logic [PAIR_W-1:0] ROW0_B_RST = 64'h0;
	localparam logic [PAIR_W-1:0] ROW1_A_RST = 64'h0001_0000_0000_0000;
	localparam logic [PAIR_W-1:0] ROW1_B_RST = 64'h0;
	localparam logic [PAIR_W-1:0] ROW2_A_RST = 64'h0;
	localparam logic [PAIR_W-1:0] ROW2_B_RST = 64'h0000_0000_0001_0000;

	// Affine coefficients: [row][col], col 3 is the translation.
	typedef logic [2:0][3:0][WORD_W-1:0] dtrd_coef_t;

	// What a decoded byte hands to the transform pipeline.
	typedef struct packed {
		logic [1:0] kind;
		logic with_point;
		logic [WORD_W-1:0] idx;
		logic last;
	} dtrd_meta_t;

	typedef struct packed {
		dtrd_meta_t meta;
		logic [2:0][WORD_W-1:0] acc;
	} dtrd_req_t;

endpackage
`default_nettype wire

[rtl/delta_track_record_decoder_top.sv]
// Delta-coded track record decoder.
// Input channel: one track buffer byte per request on track_byte, taken when
// in_valid is high and in_stall is low. Output channel: one result per request
// (kind, point_x/y/z, streamline_number, last_point), taken when out_valid is
// high and out_stall is low. Configuration is a plain write port: cfg_wr_en,
// cfg_index and cfg_data, to be written only while no request is in flight;
// the block itself does not enforce this. A byte is taken every cycle while
// in_stall is low. A byte that completes a point, a header or an error produces
// a result through the snapshot register, the multiply stage, the summing stage
// and the result register. Points arrive at most once per three bytes, so
// the four-stage transform pipeline never stalls bytes while out_stall is low.
// When out_stall holds a result, the pipeline behind it keeps filling; in_stall
// rises only once the first stage holds a request that cannot move on.
// Reset clears the decoder state, empties the pipeline and returns the affine
// to identity with zero buffer length. After a bad length or an overrun, and
// when a header would not fit, the decoder ignores bytes until reset.
`default_nettype none
module delta_track_record_decoder_top
	import dtrd_pkg::*;
#(
	parameter int SUBVOXEL_BITS = SUBVOXEL_BITS_DEF,
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [PAIR_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [BYTE_W-1:0] track_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] kind,
	output logic signed [OUT_W-1:0] point_x,
	output logic signed [OUT_W-1:0] point_y,
	output logic signed [OUT_W-1:0] point_z,
	output logic [WORD_W-1:0] streamline_number,
	output logic last_point
);

	dtrd_coef_t coef;
	logic [WORD_W-1:0] buffer_length;
	logic in_fire;
	logic req_vld;
	logic req_stall;
	dtrd_req_t req;

	assign in_stall = req_stall;
	assign in_fire = in_valid && !req_stall;

	dtrd_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.coef(coef),
		.buffer_length(buffer_length)
	);

	dtrd_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.track_byte(track_byte),
		.buffer_length(buffer_length),
		.req_vld(req_vld),
		.req(req)
	);

	dtrd_xform #(
		.SUBVOXEL_BITS(SUBVOXEL_BITS),
		.COEFF_FRAC_BITS(COEFF_FRAC_BITS)
	) u_xform (
		.clk(clk),
		.arst_n(arst_n),
		.req_vld(req_vld),
		.req(req),
		.req_stall(req_stall),
		.coef(coef),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.streamline_number(streamline_number),
		.last_point(last_point)
	);

endmodule
`default_nettype wire

[rtl/dtrd_cfg.sv]
`default_nettype none
module dtrd_cfg
	import dtrd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [PAIR_W-1:0] cfg_data,
	output dtrd_coef_t coef,
	output logic [WORD_W-1:0] buffer_length
);

	logic [2:0][PAIR_W-1:0] pair_a_q;
	logic [2:0][PAIR_W-1:0] pair_b_q;
	logic [WORD_W-1:0] buf_len_q;

	// Register writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_a_q[0] <= ROW0_A_RST;
			pair_b_q[0] <= ROW0_B_RST;
			pair_a_q[1] <= ROW1_A_RST;
			pair_b_q[1] <= ROW1_B_RST;
			pair_a_q[2] <= ROW2_A_RST;
			pair_b_q[2] <= ROW2_B_RST;
			buf_len_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ROW0_A: pair_a_q[0] <= cfg_data;
				REG_ROW0_B: pair_b_q[0] <= cfg_data;
				REG_ROW1_A: pair_a_q[1] <= cfg_data;
				REG_ROW1_B: pair_b_q[1] <= cfg_data;
				REG_ROW2_A: pair_a_q[2] <= cfg_data;
				REG_ROW2_B: pair_b_q[2] <= cfg_data;
				REG_BUF_LEN: buf_len_q <= cfg_data[WORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Unpack the pairs into the coefficient matrix.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			coef[r][0] = pair_a_q[r][WORD_W-1:0];
			coef[r][1] = pair_a_q[r][PAIR_W-1:WORD_W];
			coef[r][2] = pair_b_q[r][WORD_W-1:0];
			coef[r][3] = pair_b_q[r][PAIR_W-1:WORD_W];
		end
	end

	assign buffer_length = buf_len_q;

endmodule
`default_nettype wire

[rtl/dtrd_parse.sv]
`default_nettype none
module dtrd_parse
	import dtrd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic [BYTE_W-1:0] track_byte,
	input wire logic [WORD_W-1:0] buffer_length,
	output logic req_vld,
	output dtrd_req_t req
);

	localparam logic [1:0] PH_HDR = 2'd0;
	localparam logic [1:0] PH_DLT = 2'd1;
	localparam logic [1:0] PH_HALT = 2'd2;
	localparam logic [3:0] HC_LAST = 4'(HEADER_BYTES - 1);
	localparam int LW = WORD_W + 2;

	// Residue of a byte modulo three, folding base-4 digits since 4 is 1 mod 3.
	function automatic logic [1:0] mod3_byte(input logic [7:0] b);
		logic [3:0] s;
		logic [2:0] t;
		logic [1:0] u;
		s = 4'(b[7:6]) + 4'(b[5:4]) + 4'(b[3:2]) + 4'(b[1:0]);
		t = 3'(s[3:2]) + 3'(s[1:0]);
		u = 2'(t[2]) + t[1:0];
		return (u == 2'd3) ? 2'd0 : u;
	endfunction

	function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
		logic [2:0] s;
		s = 3'(a) + 3'(b);
		return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
	endfunction

	logic [1:0] phase_q, phase_n;
	logic [3:0] hc_q, hc_n;
	logic [WORD_W-1:0] bs_q, bs_n, rs_q, rs_n, hb_q, hb_n, lw_q, lw_n;
	logic [WORD_W-1:0] left_q, left_n, sc_q, sc_n;
	logic [2:0][WORD_W-1:0] acc_q, acc_n;
	logic [1:0] lane_q, lane_n, res_q, res_n;
	logic [WORD_W-1:0] bs_inc, hb_shift, delta, left_dec;
	logic [1:0] byte_res;
	logic [LW-1:0] rec_len;
	logic no_fit, overrun;

	assign bs_inc = bs_q + 1'b1;
	assign hb_shift = {track_byte, hb_q[WORD_W-1:BYTE_W]};
	assign delta = {{(WORD_W - BYTE_W){track_byte[BYTE_W-1]}}, track_byte};
	assign left_dec = left_q - WORD_W'(3);
	assign byte_res = mod3_byte(track_byte);

	// Record bounds: the header must fit, and the whole record must fit.
	assign no_fit = (LW'(rs_q) + LW'(HEADER_BYTES)) > LW'(buffer_length);
	assign rec_len = (lw_q == '0) ? LW'(HEADER_BYTES) : (LW'(lw_q) + LW'(HEADER_BYTES - 3));
	assign overrun = (LW'(rs_q) + rec_len) > LW'(buffer_length);

	// Next-state decode for one byte.
	always_comb begin
		phase_n = phase_q;
		hc_n = hc_q;
		bs_n = bs_q;
		rs_n = rs_q;
		hb_n = hb_q;
		lw_n = lw_q;
		left_n = left_q;
		sc_n = sc_q;
		acc_n = acc_q;
		lane_n = lane_q;
		res_n = res_q;
		req_vld = 1'b0;
		req.meta.kind = KIND_POINT;
		req.meta.with_point = 1'b0;
		req.meta.idx = sc_q;
		req.meta.last = 1'b0;
		case (phase_q)
			PH_HDR: begin
				if (in_fire) begin
					if (hc_q == '0 && no_fit) begin
						phase_n = PH_HALT;
					end else begin
						bs_n = bs_inc;
						hb_n = hb_shift;
						// The length residue builds up over the first four bytes.
						if (hc_q == '0) begin
							res_n = byte_res;
						end else if (hc_q < 4'd4) begin
							res_n = mod3_add(res_q, byte_res);
						end
						if (hc_q[1:0] == 2'd3) begin
							case (hc_q[3:2])
								2'd0: lw_n = hb_shift;
								2'd1: acc_n[0] = hb_shift;
								2'd2: acc_n[1] = hb_shift;
								default: acc_n[2] = hb_shift;
							endcase
						end
						if (hc_q != HC_LAST) begin
							hc_n = hc_q + 1'b1;
						end else begin
							hc_n = '0;
							req_vld = 1'b1;
							if (res_q != 2'd0) begin
								req.meta.kind = KIND_BAD_LEN;
								phase_n = PH_HALT;
							end else if (overrun) begin
								req.meta.kind = KIND_OVERRUN;
								phase_n = PH_HALT;
							end else begin
								sc_n = sc_q + 1'b1;
								if (lw_q == '0) begin
									req.meta.kind = KIND_EMPTY;
									rs_n = bs_inc;
								end else begin
									req.meta.with_point = 1'b1;
									if (lw_q == WORD_W'(3)) begin
										req.meta.last = 1'b1;
										rs_n = bs_inc;
									end else begin
										phase_n = PH_DLT;
										left_n = lw_q - WORD_W'(3);
										lane_n = 2'd0;
									end
								end
							end
						end
					end
				end
			end
			PH_DLT: begin
				if (in_fire) begin
					bs_n = bs_inc;
					case (lane_q)
						2'd0: begin
							acc_n[0] = acc_q[0] + delta;
							lane_n = 2'd1;
						end
						2'd1: begin
							acc_n[1] = acc_q[1] + delta;
							lane_n = 2'd2;
						end
						default: begin
							// Third byte of a triple completes a point.
							acc_n[2] = acc_q[2] + delta;
							lane_n = 2'd0;
							left_n = left_dec;
							req_vld = 1'b1;
							req.meta.with_point = 1'b1;
							req.meta.idx = sc_q - 1'b1;
							req.meta.last = (left_dec == '0);
							if (left_dec == '0) begin
								phase_n = PH_HDR;
								rs_n = bs_inc;
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		req.acc = acc_n;
	end

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			hc_q <= '0;
			bs_q <= '0;
			rs_q <= '0;
			hb_q <= '0;
			lw_q <= '0;
			left_q <= '0;
			sc_q <= '0;
			acc_q <= '0;
			lane_q <= '0;
			res_q <= '0;
		end else begin
			phase_q <= phase_n;
			hc_q <= hc_n;
			bs_q <= bs_n;
			rs_q <= rs_n;
			hb_q <= hb_n;
			lw_q <= lw_n;
			left_q <= left_n;
			sc_q <= sc_n;
			acc_q <= acc_n;
			lane_q <= lane_n;
			res_q <= res_n;
		end
	end

`ifndef SYNTHESIS
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("decoder left the halted phase");
	a_delta_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DLT |-> left_q != '0)
		else $error("delta phase with no points left");
	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q != '0 |-> phase_q == PH_HDR)
		else $error("header count active outside the header phase");
`endif

endmodule
`default_nettype wire

[rtl/dtrd_xform.sv]
`default_nettype none
module dtrd_xform
	import dtrd_pkg::*;
#(
	parameter int SUBVOXEL_BITS = SUBVOXEL_BITS_DEF,
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_vld,
	input wire dtrd_req_t req,
	output logic req_stall,
	input wire dtrd_coef_t coef,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] kind,
	output logic signed [OUT_W-1:0] point_x,
	output logic signed [OUT_W-1:0] point_y,
	output logic signed [OUT_W-1:0] point_z,
	output logic [WORD_W-1:0] streamline_number,
	output logic last_point
);

	localparam int PW = 2 * WORD_W;
	localparam int TW = WORD_W + SUBVOXEL_BITS;
	localparam int SW = PW + 3;
	localparam int K = COEFF_FRAC_BITS + SUBVOXEL_BITS - OUT_FRAC_BITS;
	localparam int KR = (K > 0) ? K : 0;
	localparam int LS = (K < 0) ? -K : 0;
	localparam logic signed [SW-1:0] SW_ONE = SW'(1);
	localparam logic signed [SW-1:0] RND = (SW_ONE <<< KR) >>> 1;
	localparam logic signed [SW-1:0] LIM_HI = ((SW_ONE <<< (OUT_W - 1)) - SW_ONE) >>> LS;
	localparam logic signed [SW-1:0] LIM_LO = (-(SW_ONE <<< (OUT_W - 1))) >>> LS;
	localparam logic signed [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W - 1){1'b0}}};

	logic vld_s1, vld_s2, vld_s3, out_vld_q;
	logic en_s1, en_s2, en_s3, en_out;
	dtrd_meta_t meta_s1, meta_s2, meta_s3;
	logic [2:0][WORD_W-1:0] acc_s1;
	logic signed [PW-1:0] prod_s2 [3][3];
	logic signed [TW-1:0] tr_s2 [3];
	logic signed [SW-1:0] sum_s3 [3];
	logic signed [SW-1:0] shifted [3];
	logic signed [OUT_W-1:0] sat_val [3];
	logic signed [OUT_W-1:0] pt_q [3];
	logic [1:0] kind_q;
	logic [WORD_W-1:0] idx_q;
	logic last_q;

	// Each stage loads when it is empty or its contents move on.
	assign en_out = !out_vld_q || !out_stall;
	assign en_s3 = !vld_s3 || en_out;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign req_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= req_vld;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_out) out_vld_q <= vld_s3;
		end
	end

	// Stage 1: accumulator snapshot of the decoded point.
	always_ff @(posedge clk) begin
		if (en_s1 && req_vld) begin
			meta_s1 <= req.meta;
			acc_s1 <= req.acc;
		end
	end

	// Stage 2: nine coefficient products and the scaled translations.
	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			meta_s2 <= meta_s1;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= PW'(signed'(coef[r][c])) * PW'(signed'(acc_s1[c]));
				end
				tr_s2[r] <= TW'(signed'(coef[r][3])) <<< SUBVOXEL_BITS;
			end
		end
	end

	// Stage 3: row sums with the rounding half added.
	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			meta_s3 <= meta_s2;
			for (int r = 0; r < 3; r++) begin
				sum_s3[r] <= SW'(prod_s2[r][0]) + SW'(prod_s2[r][1]) + SW'(prod_s2[r][2])
					+ SW'(tr_s2[r]) + RND;
			end
		end
	end

	// Rescale to the output fraction and saturate to the output range.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			shifted[r] = sum_s3[r] >>> KR;
			if (shifted[r] > LIM_HI) begin
				sat_val[r] = SAT_HI;
			end else if (shifted[r] < LIM_LO) begin
				sat_val[r] = SAT_LO;
			end else begin
				sat_val[r] = OUT_W'(shifted[r] <<< LS);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (en_out && vld_s3) begin
			kind_q <= meta_s3.kind;
			idx_q <= meta_s3.idx;
			last_q <= meta_s3.last;
			for (int r = 0; r < 3; r++) begin
				pt_q[r] <= meta_s3.with_point ? sat_val[r] : '0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign kind = kind_q;
	assign point_x = pt_q[0];
	assign point_y = pt_q[1];
	assign point_z = pt_q[2];
	assign streamline_number = idx_q;
	assign last_point = last_q;

`ifndef SYNTHESIS
	a_no_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && kind_q != KIND_POINT |-> pt_q[0] == '0 && pt_q[1] == '0 && pt_q[2] == '0)
		else $error("non-point result carries coordinates");
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !en_s2 |=> vld_s1 && $stable(meta_s1))
		else $error("blocked stage one lost its request");
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && last_q |-> kind_q == KIND_POINT)
		else $error("last flag on a non-point result");
`endif

endmodule
`default_nettype wire

[tb/sv/delta_track_record_decoder_top_tb.sv]
`timescale 1ns / 1ps
module delta_track_record_decoder_top_tb;
	import dtrd_pkg::*;

	localparam int N_BYTES = 1200;
	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int NUM_REGS = 7;
	localparam int NUM_PAIRS = 6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [PAIR_W-1:0] PAIR_RST [NUM_PAIRS] = '{ROW0_A_RST, ROW0_B_RST,
		ROW1_A_RST, ROW1_B_RST, ROW2_A_RST, ROW2_B_RST};
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef enum logic [1:0] {DEC_HEADER, DEC_DELTAS, DEC_HALTED} dec_state_e;
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;
	typedef enum {END_NO_ROOM, END_BAD_LENGTH, END_OVERRUN} ending_e;

	typedef struct {
		logic [1:0] kind;
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
		logic [WORD_W-1:0] line;
		logic last;
	} track_result_t;

	// Decoder state mirror plus the queue of results still owed by the block.
	class track_decode_sb;
		logic [PAIR_W-1:0] coef_pair [NUM_PAIRS];
		logic [WORD_W-1:0] buf_len;
		logic [WORD_W-1:0] bytes_seen, record_start, header_word, length_word;
		logic [WORD_W-1:0] points_left, line_count;
		logic [WORD_W-1:0] acc [3];
		logic [3:0] header_count;
		logic [1:0] lane;
		dec_state_e state;
		track_result_t due_results [$];
		int errors;

		function new();
			coef_pair = PAIR_RST;
			buf_len = '0;
			bytes_seen = '0;
			record_start = '0;
			header_word = '0;
			length_word = '0;
			points_left = '0;
			line_count = '0;
			acc = '{default: '0};
			header_count = '0;
			lane = '0;
			state = DEC_HEADER;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAIR_W-1:0] val);
			if (idx <= REG_ROW2_B) begin
				coef_pair[idx] = val;
			end else if (idx == REG_BUF_LEN) begin
				buf_len = val[WORD_W-1:0];
			end
		endfunction

		// One scanner axis from the accumulators: exact sum, round half up, saturate.
		function logic signed [OUT_W-1:0] map_axis(int row);
			logic signed [127:0] sum;
			logic signed [127:0] term;
			logic signed [WORD_W-1:0] m [4];
			int shift;
			int c;
			m[0] = coef_pair[2 * row][WORD_W-1:0];
			m[1] = coef_pair[2 * row][PAIR_W-1:WORD_W];
			m[2] = coef_pair[2 * row + 1][WORD_W-1:0];
			m[3] = coef_pair[2 * row + 1][PAIR_W-1:WORD_W];
			sum = '0;
			for (c = 0; c < 3; c++) begin
				term = 128'(m[c]);
				sum = sum + term * $signed(acc[c]);
			end
			term = 128'(m[3]);
			sum = sum + (term <<< SUBVOXEL_BITS_DEF);
			shift = COEFF_FRAC_BITS_DEF + SUBVOXEL_BITS_DEF - OUT_FRAC_BITS;
			if (shift > 0) begin
				sum = (sum + (128'sd1 <<< (shift - 1))) >>> shift;
			end else begin
				sum = sum <<< (-shift);
			end
			if (sum > OUT_MAX) begin
				return OUT_MAX;
			end
			if (sum < OUT_MIN) begin
				return OUT_MIN;
			end
			return sum[OUT_W-1:0];
		endfunction

		function void add_result(logic [1:0] kind, bit with_point, logic [WORD_W-1:0] line,
				bit last);
			track_result_t r;
			r.kind = kind;
			r.x = with_point ? map_axis(0) : '0;
			r.y = with_point ? map_axis(1) : '0;
			r.z = with_point ? map_axis(2) : '0;
			r.line = line;
			r.last = last;
			due_results = {due_results, r};
		endfunction

		// The sixteenth header byte: check the length word, then the buffer bound.
		function void close_header();
			logic [WORD_W-1:0] npts;
			logic [63:0] span;
			npts = length_word / 3;
			span = 64'(HEADER_BYTES);
			if (npts != 0) begin
				span = span + 3 * (64'(npts) - 64'd1);
			end
			if (length_word % 3 != 0) begin
				state = DEC_HALTED;
				add_result(KIND_BAD_LEN, 1'b0, line_count, 1'b0);
			end else if (64'(record_start) + span > 64'(buf_len)) begin
				state = DEC_HALTED;
				add_result(KIND_OVERRUN, 1'b0, line_count, 1'b0);
			end else begin
				if (npts == 0) begin
					add_result(KIND_EMPTY, 1'b0, line_count, 1'b0);
					record_start = bytes_seen;
				end else begin
					add_result(KIND_POINT, 1'b1, line_count, npts == 1);
					if (npts == 1) begin
						record_start = bytes_seen;
					end else begin
						state = DEC_DELTAS;
						points_left = npts - 1;
						lane = '0;
					end
				end
				line_count++;
			end
		endfunction

		// Accepted track byte: advance the decoder and queue any result it causes.
		function void take_byte(logic [BYTE_W-1:0] b);
			if (state == DEC_HEADER) begin
				if (header_count == 0 &&
						64'(record_start) + 64'(HEADER_BYTES) > 64'(buf_len)) begin
					state = DEC_HALTED;
				end else begin
					bytes_seen++;
					header_word = {b, header_word[WORD_W-1:BYTE_W]};
					if (header_count[1:0] == 2'd3) begin
						case (header_count[3:2])
						2'd0: length_word = header_word;
						2'd1: acc[0] = header_word;
						2'd2: acc[1] = header_word;
						default: acc[2] = header_word;
						endcase
					end
					if (header_count == 4'(HEADER_BYTES - 1)) begin
						header_count = '0;
						close_header();
					end else begin
						header_count++;
					end
				end
			end else if (state == DEC_DELTAS) begin
				bytes_seen++;
				acc[lane] = acc[lane] + {{(WORD_W - BYTE_W){b[BYTE_W-1]}}, b};
				if (lane != 2'd2) begin
					lane++;
				end else begin
					lane = '0;
					points_left--;
					add_result(KIND_POINT, 1'b1, line_count - 1, points_left == 0);
					if (points_left == 0) begin
						state = DEC_HEADER;
						record_start = bytes_seen;
					end
				end
			end
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("%s", msg);
			end
		endfunction

		function void check_result(track_result_t got);
			track_result_t want;
			if (due_results.size() == 0) begin
				flag($sformatf("unexpected result: kind %0d line %0d x %0d y %0d z %0d",
					got.kind, got.line, got.x, got.y, got.z));
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
					got.z !== want.z || got.line !== want.line || got.last !== want.last) begin
				flag({$sformatf("mismatch: expected kind %0d line %0d last %0b xyz %0d %0d %0d",
					want.kind, want.line, want.last, want.x, want.y, want.z),
					$sformatf(", got kind %0d line %0d last %0b xyz %0d %0d %0d",
					got.kind, got.line, got.last, got.x, got.y, got.z)});
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PAIR_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [BYTE_W-1:0] track_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind;
	logic signed [OUT_W-1:0] point_x;
	logic signed [OUT_W-1:0] point_y;
	logic signed [OUT_W-1:0] point_z;
	logic [WORD_W-1:0] streamline_number;
	logic last_point;

	track_decode_sb sb;
	track_result_t observed;
	logic [PAIR_W-1:0] reg_plan [NUM_REGS];
	int bytes_sent = 0;
	int burst_left = 0;
	int quiet_cycles = 0;
	stall_mode_e stall_mode = STALL_NONE;
	int mode_left = 0;
	int stall_phase = 0;

	delta_track_record_decoder_top i_dut (.*);

	always #2 clk = ~clk;

	// Mirror every accepted request and register write, and check every result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				observed = '{kind, point_x, point_y, point_z, streamline_number, last_point};
				sb.check_result(observed);
			end
			if (cfg_wr_en) begin
				sb.write_reg(cfg_index, cfg_data);
			end
			if (in_valid && !in_stall) begin
				sb.take_byte(track_byte);
			end
		end
	end

	// Watchdog: give up when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	// Result side backpressure: modes of random length, including no stalls at all.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 256);
		end
		mode_left--;
		stall_phase = (stall_phase + 1) % 5;
		case (stall_mode)
		STALL_NONE: out_stall <= 1'b0;
		STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
		STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
		default: out_stall <= (stall_phase < 2);
		endcase
	end

	// Sends one byte request; the sender works in bursts, mostly with gaps between them.
	task automatic push_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		track_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// Stop sending and let every owed result come out, then let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes the unused index with junk, then reg_plan from index first upward.
	task automatic program_regs(input int first);
		int i;
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_SPARE;
		cfg_data <= {$urandom, $urandom};
		@(posedge clk);
		for (i = first; i < NUM_REGS; i++) begin
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= reg_plan[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Little-endian header followed by delta triples biased toward the extremes.
	task automatic send_record(input logic [WORD_W-1:0] len, input logic [WORD_W-1:0] x,
			input logic [WORD_W-1:0] y, input logic [WORD_W-1:0] z, input int ndeltas);
		logic [4*WORD_W-1:0] header;
		logic [BYTE_W-1:0] d;
		int i;
		header = {z, y, x, len};
		for (i = 0; i < HEADER_BYTES; i++) begin
			push_byte(header[BYTE_W*i +: BYTE_W]);
		end
		for (i = 0; i < 3 * ndeltas; i++) begin
			case ($urandom_range(0, 7))
			0: d = 8'h7F;
			1: d = 8'h80;
			2: d = 8'hFF;
			3: d = 8'h01;
			default: d = BYTE_W'($urandom);
			endcase
			push_byte(d);
		end
	endtask

	function automatic logic [WORD_W-1:0] pick_coord();
		case ($urandom_range(0, 5))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return '0;
		3: return 32'hFFFF_FFFF;
		4: return WORD_W'($urandom_range(0, 4095)) - 32'd2048;
		default: return $urandom;
		endcase
	endfunction

	// Mostly short streamlines, some single points and empties, a few long ones.
	function automatic int pick_points();
		case ($urandom_range(0, 9))
		0: return 0;
		1: return 1;
		2: return $urandom_range(30, 60);
		default: return $urandom_range(2, 10);
		endcase
	endfunction

	initial begin
		int phase_no;
		int mode;
		int npts;
		int budget;
		int start;
		int i;
		ending_e ending;
		logic [WORD_W-1:0] len;

		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: identity transform, extreme first vertex, then an empty record.
		reg_plan[REG_BUF_LEN] = {$urandom, 32'hFFFF_FFFF};
		program_regs(REG_BUF_LEN);
		send_record(32'd6, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1);
		send_record(32'd0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 0);

		// Random phases, each with its own transform and buffer bound.
		phase_no = 0;
		while (bytes_sent < N_BYTES) begin
			wait_idle();
			mode = (phase_no < NUM_PAIRS) ? phase_no : $urandom_range(0, NUM_PAIRS - 1);
			for (i = 0; i < NUM_PAIRS; i++) begin
				case (mode)
				0: begin
					reg_plan[i] = PAIR_RST[i];
					if (i % 2 == 1) begin
						reg_plan[i][PAIR_W-1:WORD_W] = $urandom_range(0, 1 << 22) - (1 << 21);
					end
				end
				1: reg_plan[i] = {$urandom, $urandom};
				2: reg_plan[i] = 64'h7FFF_FFFF_7FFF_FFFF;
				3: reg_plan[i] = 64'h8000_0000_8000_0000;
				4: reg_plan[i] = '0;
				default: reg_plan[i] = {WORD_W'($urandom_range(0, 1 << 18) - (1 << 17)),
					WORD_W'($urandom_range(0, 1 << 18) - (1 << 17))};
				endcase
			end
			npts = pick_points();
			if ($urandom_range(0, 3) == 0) begin
				// The bound ends exactly where the next record ends.
				reg_plan[REG_BUF_LEN] = {$urandom,
					WORD_W'(bytes_sent + HEADER_BYTES + ((npts != 0) ? 3 * (npts - 1) : 0))};
				program_regs(REG_ROW0_A);
				send_record(WORD_W'(3 * npts), pick_coord(), pick_coord(), pick_coord(),
					(npts != 0) ? npts - 1 : 0);
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					reg_plan[REG_BUF_LEN] = {$urandom, 32'hFFFF_FFFF};
				end else begin
					reg_plan[REG_BUF_LEN] = {$urandom,
						WORD_W'(bytes_sent + 4096 + $urandom_range(0, 1 << 20))};
				end
				program_regs(REG_ROW0_A);
				budget = $urandom_range(60, 220);
				start = bytes_sent;
				while (bytes_sent - start < budget) begin
					send_record(WORD_W'(3 * npts), pick_coord(), pick_coord(), pick_coord(),
						(npts != 0) ? npts - 1 : 0);
					npts = pick_points();
				end
			end
			phase_no++;
		end

		// One terminal case, since the block stays halted until reset.
		wait_idle();
		ending = ending_e'($urandom_range(0, 2));
		reg_plan[REG_BUF_LEN] = {$urandom, 32'hFFFF_FFFF};
		case (ending)
		END_NO_ROOM: begin
			if ($urandom_range(0, 1) == 0) begin
				reg_plan[REG_BUF_LEN] = {$urandom, 32'h0};
			end else begin
				reg_plan[REG_BUF_LEN] = {$urandom, WORD_W'(bytes_sent + $urandom_range(0, 15))};
			end
			program_regs(REG_BUF_LEN);
		end
		END_BAD_LENGTH: begin
			program_regs(REG_BUF_LEN);
			if ($urandom_range(0, 1) == 0) begin
				len = 32'hFFFF_FFFE;
			end else begin
				len = WORD_W'(3 * $urandom_range(0, 20) + $urandom_range(1, 2));
			end
			send_record(len, pick_coord(), pick_coord(), pick_coord(), 2);
		end
		default: begin
			npts = $urandom_range(2, 20);
			if ($urandom_range(0, 1) == 0) begin
				len = 32'hFFFF_FFFF;
			end else begin
				len = WORD_W'(3 * npts);
				reg_plan[REG_BUF_LEN] = {$urandom,
					WORD_W'(bytes_sent + HEADER_BYTES + 3 * (npts - 1) - 1)};
			end
			program_regs(REG_BUF_LEN);
			send_record(len, pick_coord(), pick_coord(), pick_coord(), npts - 1);
		end
		endcase
		// Bytes after the halt must be taken and ignored.
		repeat (24) push_byte(BYTE_W'($urandom));

		wait_idle();
		if (sb.errors == 0 && sb.due_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
